// File: rtl/cbphd_pkg.sv
// Types, codes and lookup tables shared by the cell broadcast page header decoder.
`timescale 1ns / 1ps

package cbphd_pkg;

  // One raw page header word as it arrives from the receiver front end.
  typedef struct packed {
    logic [6:0] page_length;
    logic [7:0] serial_high;
    logic [7:0] serial_low;
    logic [7:0] id_high;
    logic [7:0] id_low;
    logic [7:0] coding_scheme;
    logic [7:0] page_byte;
    logic [7:0] text_byte0;
    logic [7:0] text_byte1;
  } item_t;

  // One decoded header word.
  typedef struct packed {
    logic [1:0] geo_scope;
    logic [9:0] message_code;
    logic [3:0] update_number;
    logic [15:0] message_id;
    logic [3:0] page_index;
    logic [3:0] page_count;
    logic [1:0] coding;
    logic       compressed;
    logic [2:0] msg_class;
    logic [5:0] language;
    logic [1:0] dcs_status;
    logic [6:0] content_length;
  } result_t;

  // Character coding codes.
  localparam logic [1:0] CodingGsm7 = 2'd0;
  localparam logic [1:0] CodingData8 = 2'd1;
  localparam logic [1:0] CodingUcs2 = 2'd2;
  localparam logic [1:0] CodingReserved = 2'd3;

  // Decode status codes.
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBadCoding = 2'd1;
  localparam logic [1:0] StatusBadGroup = 2'd2;

  // Message class codes beyond the four real classes.
  localparam logic [2:0] ClassNone = 3'd4;
  localparam logic [2:0] ClassNotGiven = 3'd5;

  // Language code used when nothing else applies.
  localparam logic [5:0] LangEnglish = 6'd1;

  // Coding group codes (DCS bits 7-4) with special handling.
  localparam logic [3:0] GroupLangGerman = 4'h0;
  localparam logic [3:0] GroupLangIso = 4'h1;
  localparam logic [3:0] GroupLangMore = 4'h2;
  localparam logic [3:0] GroupLangMisc = 4'h3;
  localparam logic [3:0] GroupGeneralLo = 4'h4;
  localparam logic [3:0] GroupGeneralHi = 4'h7;
  localparam logic [3:0] GroupMessage = 4'h9;
  localparam logic [3:0] GroupDataClass = 4'hf;

  // Page geometry and content length limits.
  localparam logic [6:0] HeaderBytes = 7'd6;
  localparam logic [6:0] MaxPageData = 7'd82;
  localparam logic [7:0] MaxRawChars = 8'd93;

  // floor(d / 7) for d below 128 equals (d * 147) >> 10.
  localparam logic [14:0] DivSevenMul = 15'd147;

  // ISO 639 language table: two 7-bit characters and the language code.
  localparam int LangEntries = 20;
  localparam logic [6:0] LangFirst [LangEntries] = '{
    7'h64, 7'h65, 7'h69, 7'h66, 7'h65, 7'h6e, 7'h73, 7'h64, 7'h70, 7'h66,
    7'h6e, 7'h65, 7'h74, 7'h68, 7'h70, 7'h63, 7'h68, 7'h61, 7'h72, 7'h69
  };
  localparam logic [6:0] LangSecond [LangEntries] = '{
    7'h65, 7'h6e, 7'h74, 7'h72, 7'h73, 7'h6c, 7'h76, 7'h61, 7'h74, 7'h69,
    7'h6f, 7'h6c, 7'h72, 7'h75, 7'h6c, 7'h73, 7'h65, 7'h72, 7'h75, 7'h73
  };
  localparam logic [5:0] LangCode [LangEntries] = '{
    6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h06, 6'h07, 6'h08, 6'h09,
    6'h0a, 6'h0b, 6'h0c, 6'h0d, 6'h0e, 6'h20, 6'h21, 6'h22, 6'h23, 6'h24
  };

  // Match two characters against the table; the lowest matching entry wins.
  function automatic logic [5:0] lang_lookup(logic [6:0] c0, logic [6:0] c1);
    logic [5:0] code;
    code = LangEnglish;
    for (int i = LangEntries - 1; i >= 0; i--) begin
      if (LangFirst[i] == c0 && LangSecond[i] == c1) begin
        code = LangCode[i];
      end
    end
    return code;
  endfunction

endpackage

// File: rtl/cb_page_header_decoder.sv
// Top level of the cell broadcast page header decoder.
`timescale 1ns / 1ps

// Channel   Handshake              Word
// input     start / busy           item_i   (cbphd_pkg::item_t)
// result    done_o strobe          result_o (cbphd_pkg::result_t)
//
// Each word is registered on entry, decoded in combinational logic and
// registered again, and its result shows from that second register.
// A new word can be taken in every cycle; busy stays low.
// Reset clears the valid flags of both registers, so a word in flight is dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.

module cb_page_header_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cbphd_pkg::item_t    item_i,
  output logic                done_o,
  output cbphd_pkg::result_t  result_o
);

  logic               in_vld_q;
  cbphd_pkg::item_t   item_q;
  logic               done_q;
  cbphd_pkg::result_t res_q;
  cbphd_pkg::result_t res_d;

  logic [3:0]  group;
  logic [7:0]  dcs;
  logic [1:0]  sel;
  logic [6:0]  char0;
  logic [6:0]  char1;
  logic [3:0]  pidx;
  logic [3:0]  pcnt;
  logic [6:0]  dlen;
  logic [14:0] prod;
  logic [7:0]  raw_chars;

  // The decoder never holds off a new word.
  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= item_i;
    end
  end

  assign dcs   = item_q.coding_scheme;
  assign group = dcs[7:4];
  assign sel   = dcs[3:2];
  assign char0 = item_q.text_byte0[6:0];
  assign char1 = {item_q.text_byte1[5:0], item_q.text_byte0[7]};

  // Page parameter: a zero in either nibble makes the page 1 of 1.
  always_comb begin
    pidx = item_q.page_byte[7:4];
    pcnt = item_q.page_byte[3:0];
    if (pidx == 4'd0 || pcnt == 4'd0) begin
      pidx = 4'd1;
      pcnt = 4'd1;
    end
  end

  // Data bytes after the header, and 8/7 of it as d + floor(d / 7).
  assign dlen = (item_q.page_length >= cbphd_pkg::HeaderBytes) ?
                (item_q.page_length - cbphd_pkg::HeaderBytes) : 7'd0;
  assign prod = {8'd0, dlen} * cbphd_pkg::DivSevenMul;
  assign raw_chars = {1'b0, dlen} + {3'd0, prod[14:10]};

  // Data coding scheme decode and result assembly.
  always_comb begin
    res_d = '0;
    res_d.geo_scope     = item_q.serial_high[7:6];
    res_d.message_code  = {item_q.serial_high[5:0], item_q.serial_low[7:4]};
    res_d.update_number = item_q.serial_low[3:0];
    res_d.message_id    = {item_q.id_high, item_q.id_low};
    res_d.page_index    = pidx;
    res_d.page_count    = pcnt;
    res_d.coding        = cbphd_pkg::CodingGsm7;
    res_d.compressed    = 1'b0;
    res_d.msg_class     = cbphd_pkg::ClassNotGiven;
    res_d.language      = cbphd_pkg::LangEnglish;
    res_d.dcs_status    = cbphd_pkg::StatusOk;

    case (group) inside
      cbphd_pkg::GroupLangGerman, cbphd_pkg::GroupLangMore,
      cbphd_pkg::GroupLangMisc: begin
        res_d.language = {2'b00, dcs[3:0]};
      end
      cbphd_pkg::GroupLangIso: begin
        // Reserved codings keep the defaults and read no characters.
        if (dcs[3:0] == 4'd0) begin
          res_d.language = cbphd_pkg::lang_lookup(char0, char1);
        end else if (dcs[3:0] == 4'd1) begin
          res_d.coding   = cbphd_pkg::CodingUcs2;
          res_d.language = cbphd_pkg::lang_lookup(char0, char1);
        end
      end
      [cbphd_pkg::GroupGeneralLo:cbphd_pkg::GroupGeneralHi]: begin
        if (sel == cbphd_pkg::CodingReserved) begin
          res_d.dcs_status = cbphd_pkg::StatusBadCoding;
        end else begin
          res_d.coding = sel;
        end
        res_d.compressed = dcs[5];
        res_d.msg_class  = dcs[4] ? {1'b0, dcs[1:0]} : cbphd_pkg::ClassNone;
      end
      cbphd_pkg::GroupMessage: begin
        if (sel == cbphd_pkg::CodingReserved) begin
          res_d.dcs_status = cbphd_pkg::StatusBadCoding;
        end else begin
          res_d.coding = sel;
        end
        res_d.msg_class = {1'b0, dcs[1:0]};
      end
      cbphd_pkg::GroupDataClass: begin
        res_d.coding    = dcs[2] ? cbphd_pkg::CodingData8 : cbphd_pkg::CodingGsm7;
        res_d.msg_class = (dcs[1:0] == 2'd0) ? cbphd_pkg::ClassNone : {1'b0, dcs[1:0]};
      end
      default: begin
        res_d.dcs_status = cbphd_pkg::StatusBadGroup;
      end
    endcase

    // Content length, saturated at the limit for the chosen coding.
    if (res_d.coding == cbphd_pkg::CodingGsm7) begin
      res_d.content_length = (raw_chars > cbphd_pkg::MaxRawChars) ?
                             cbphd_pkg::MaxRawChars[6:0] : raw_chars[6:0];
    end else begin
      res_d.content_length = (dlen > cbphd_pkg::MaxPageData) ?
                             cbphd_pkg::MaxPageData : dlen;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: rtl/cbphd_checker.sv
// Port-level checker for the cell broadcast page header decoder, with its bind.
`timescale 1ns / 1ps

module cbphd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input cbphd_pkg::item_t   item_i,
  input logic               done_o,
  input cbphd_pkg::result_t result_o
);

  // Every accepted word gives a result after the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted word produced no result");

  // A result appears only for a word accepted through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##2 !done_o)
    else $error("result without an accepted word");

  // The message identifier is carried from the word that caused the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2
    (result_o.message_id == {$past(item_i.id_high, 2), $past(item_i.id_low, 2)}))
    else $error("message identifier does not match its word");

  // Page index and count are never zero; a zero page count nibble gives page 1 of 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.page_byte[3:0] == 4'd0) |-> ##2
    (result_o.page_index == 4'd1 && result_o.page_count == 4'd1))
    else $error("empty page count not mapped to page 1 of 1");

  // Content length stays within the larger saturation limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.content_length <= cbphd_pkg::MaxRawChars[6:0]))
    else $error("content length beyond its limit");

endmodule

bind cb_page_header_decoder cbphd_checker u_cbphd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);
